FILE: hdl/servo_trapezoid_stepper_defines.svh
// ----------------------------------------------------------------------------
// Servo trapezoid stepper - assertion macros
// Shared concurrent assertion shorthands, sampled on the rising clock edge
// and disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef SERVO_TRAPEZOID_STEPPER_DEFINES_SVH
`define SERVO_TRAPEZOID_STEPPER_DEFINES_SVH

// same-cycle implication
`define STP_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define STP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/stp_pkg.sv
// ----------------------------------------------------------------------------
// Servo trapezoid stepper - package
// Field widths, limits and register codes shared by the stepper files.
// ----------------------------------------------------------------------------
`default_nettype none

package stp_pkg;

  // item fields
  localparam int unsigned DegW     = 8;
  localparam int unsigned PulseW   = 11;
  localparam int unsigned DwellW   = 30;

  // configuration
  localparam int unsigned VW       = 20;
  localparam int unsigned AW       = 24;
  localparam int unsigned KW       = 31;  // holds 200 * accel
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 24;

  // datapath
  localparam int unsigned StepW    = 8;   // step counts up to 180
  localparam int unsigned SqW      = 40;  // V^2 and d * 200A
  localparam int unsigned MulBW    = 20;
  localparam int unsigned RadW     = 46;  // 2000A(10n+1)
  localparam int unsigned RootW    = RadW / 2;
  localparam int unsigned SpW      = 24;  // speed in milli-deg/s

  localparam logic signed [DegW-1:0] PosMax = 8'sd90;
  localparam logic signed [DegW-1:0] PosMin = -8'sd90;

  localparam logic [VW-1:0]     VMin     = 20'd10;
  localparam logic [VW-1:0]     VMax     = 20'd1000000;
  localparam logic [AW-1:0]     AMin     = 24'd1;
  localparam logic [AW-1:0]     AMax     = 24'd10000000;
  localparam logic [DwellW-1:0] DwellNum = 30'd1000000000;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MAX_SPEED = 1'b0,
    REG_ACCEL     = 1'b1
  } cfg_reg_e;

endpackage

`default_nettype wire

FILE: hdl/stp_if.sv
// ----------------------------------------------------------------------------
// Servo trapezoid stepper - channel interfaces
// Valid/ready channels for requests, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface stp_in_if;
  import stp_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   req_type;
  logic signed [DegW-1:0] target_degrees;

  modport source (output valid, output req_type, output target_degrees, input ready);
  modport sink   (input valid, input req_type, input target_degrees, output ready);
endinterface

interface stp_out_if;
  import stp_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [DegW-1:0] position_deg;
  logic [PulseW-1:0]      pulse_us;
  logic [DwellW-1:0]      dwell_us;
  logic                   last_step;
  logic                   idle;

  modport source (output valid, output position_deg, output pulse_us, output dwell_us,
                  output last_step, output idle, input ready);
  modport sink   (input valid, input position_deg, input pulse_us, input dwell_us,
                  input last_step, input idle, output ready);
endinterface

interface stp_cfg_if;
  import stp_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/stp_mul.sv
// ----------------------------------------------------------------------------
// Servo trapezoid stepper - serial multiplier
// Shift-and-add, one multiplier bit per cycle, LSB first; stops as soon as
// the remaining multiplier bits are all zero.
// ----------------------------------------------------------------------------
`default_nettype none

module stp_mul #(
  parameter int unsigned OpAW = 31,
  parameter int unsigned OpBW = 20
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [OpAW-1:0]      a_i,
  input  wire logic [OpBW-1:0]      b_i,
  output logic                      done_o,
  output logic [OpAW+OpBW-1:0]      prod_o
);

  localparam int unsigned PW = OpAW + OpBW;

  logic          busy_q, done_q;
  logic [PW-1:0] a_q, acc_q;
  logic [OpBW-1:0] b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && (b_q == '0)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= PW'(a_i);
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q && (b_q != '0)) begin
      if (b_q[0]) begin
        acc_q <= acc_q + a_q;
      end
      a_q <= a_q << 1;
      b_q <= b_q >> 1;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

`default_nettype wire

FILE: hdl/stp_isqrt.sv
// ----------------------------------------------------------------------------
// Servo trapezoid stepper - serial square root
// Digit-by-digit integer square root, two radicand bits and one root bit
// per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module stp_isqrt #(
  parameter int unsigned XW = 46
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [XW-1:0]   x_i,
  output logic                 done_o,
  output logic [XW/2-1:0]      root_o
);

  localparam int unsigned QW   = XW / 2;
  localparam int unsigned RemW = QW + 3;
  localparam int unsigned CntW = $clog2(QW);

  logic            busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [XW-1:0]   x_q;
  logic [RemW-1:0] rem_q;
  logic [QW-1:0]   root_q;

  logic [RemW-1:0] rem_sh, trial;
  logic            ge;

  // remainder stays below 2*root + 1, so its top two bits are free to shift out
  assign rem_sh = {rem_q[RemW-3:0], x_q[XW-1:XW-2]};
  assign trial  = RemW'({root_q, 2'b01});
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(QW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= x_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      x_q    <= x_q << 2;
      rem_q  <= ge ? (rem_sh - trial) : rem_sh;
      root_q <= {root_q[QW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

FILE: hdl/stp_div.sv
// ----------------------------------------------------------------------------
// Servo trapezoid stepper - serial divider
// Restoring division, one quotient bit per cycle.
// Divisor must be non-zero.
// ----------------------------------------------------------------------------
`default_nettype none

module stp_div #(
  parameter int unsigned NW = 30,
  parameter int unsigned DW = 24
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  output logic               done_o,
  output logic [NW-1:0]      quo_o
);

  localparam int unsigned CntW = $clog2(NW);

  logic            busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [NW-1:0]   num_q, quo_q;
  logic [DW-1:0]   den_q, rem_q;

  logic [DW:0]     rem_sh, diff;
  logic            ge;

  assign rem_sh = {rem_q, num_q[NW-1]};
  assign diff   = rem_sh - {1'b0, den_q};
  assign ge     = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(NW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      num_q <= num_q << 1;
      rem_q <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
      quo_q <= {quo_q[NW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

FILE: hdl/servo_trapezoid_stepper.sv
// ----------------------------------------------------------------------------
// Servo trapezoid stepper - top level
// Steps a servo one degree per request with trapezoidal step timing.
// ----------------------------------------------------------------------------
// A start request (req_type 0) latches a target clamped to +/-90 degrees and
// is taken with no result. A step request (req_type 1) gives one result: new
// position, pulse width and the dwell before the next step. A step with no move
// in progress goes straight to the output state and is answered with dwell 0
// and idle set. A step during a move runs a sequencer over three serial units:
// a bit-serial multiplier (one multiplier bit per cycle) forms V^2, d*200A,
// (T-d)*200A and the radicand; a digit-serial square root runs 23 iterations;
// a restoring divider forms the dwell in 30 iterations. A cruise step skips the
// radicand and the root; an acceleration or deceleration step runs both. The
// root and divider always run all their iterations; each multiply ends once
// its remaining multiplier bits are zero, so its length varies with the bit
// counts of V (up to 20), d and T-d. New requests are taken only between
// steps; a finished result waits in the output register without holding up
// the next request.
// ----------------------------------------------------------------------------
`default_nettype none
`include "servo_trapezoid_stepper_defines.svh"

module servo_trapezoid_stepper (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  stp_in_if.sink    in_i,
  stp_out_if.source out_o,
  stp_cfg_if.sink   cfg_i
);

  import stp_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_SQ   = 8'b0000_0010,
    ST_P1   = 8'b0000_0100,
    ST_P2   = 8'b0000_1000,
    ST_RAD  = 8'b0001_0000,
    ST_ROOT = 8'b0010_0000,
    ST_DIV  = 8'b0100_0000,
    ST_OUT  = 8'b1000_0000
  } state_e;

  localparam int unsigned ProdW = KW + MulBW;

  function automatic logic [PulseW-1:0] pulse_for(input logic [DegW-1:0] off);
    logic [13:0] y;
    logic [26:0] z;
    // floor(off*50/9) via reciprocal 7282/65536, exact for off up to 180
    y = (14'(off) << 5) + (14'(off) << 4) + (14'(off) << 1);
    z = 27'(y) * 27'd7282;
    return PulseW'(11'd1000 + 11'(z[26:16]));
  endfunction

  // ---- state ----
  state_e                 state_q;
  logic                   go_q;
  logic [VW-1:0]          v_q;
  logic [KW-1:0]          k_q;
  logic signed [DegW-1:0] pos_q;
  logic [StepW-1:0]       total_q, done_cnt_q;
  logic                   moving_q, dir_neg_q;

  logic [SqW-1:0]         v2_q, p1_q;
  logic [StepW-1:0]       n_q;
  logic [SpW-1:0]         sp_q;
  logic [DwellW-1:0]      dwell_q;
  logic                   res_last_q, res_idle_q;

  logic                   out_valid_q;
  logic signed [DegW-1:0] out_pos_q;
  logic [PulseW-1:0]      out_pulse_q;
  logic [DwellW-1:0]      out_dwell_q;
  logic                   out_last_q, out_idle_q;

  // ---- handshakes ----
  logic in_acc, cfg_acc, out_free;

  assign in_i.ready  = state_q == ST_IDLE;
  assign cfg_i.ready = 1'b1;
  assign in_acc      = in_i.valid && in_i.ready;
  assign cfg_acc     = cfg_i.valid && cfg_i.ready;
  assign out_free    = !out_valid_q || out_o.ready;

  // ---- start request ----
  logic signed [DegW-1:0] tgt_c;
  logic signed [DegW:0]   diff, mag;

  always_comb begin
    if (in_i.target_degrees > PosMax) begin
      tgt_c = PosMax;
    end else if (in_i.target_degrees < PosMin) begin
      tgt_c = PosMin;
    end else begin
      tgt_c = in_i.target_degrees;
    end
    diff = (DegW+1)'(tgt_c) - (DegW+1)'(pos_q);
    mag  = diff[DegW] ? -diff : diff;
  end

  // ---- configuration ----
  logic [VW-1:0] v_w;
  logic [AW-1:0] a_w;

  always_comb begin
    v_w = cfg_i.data[VW-1:0];
    if (v_w < VMin) begin
      v_w = VMin;
    end else if (v_w > VMax) begin
      v_w = VMax;
    end
    a_w = cfg_i.data[AW-1:0];
    if (a_w < AMin) begin
      a_w = AMin;
    end else if (a_w > AMax) begin
      a_w = AMax;
    end
  end

  // ---- step arithmetic ----
  logic [StepW-1:0] cnt_inc, rem;
  logic             half, accel, cruise;
  logic [14:0]      rad_b;
  logic [SpW-1:0]   cruise_sp;

  logic             mul_start, mul_done;
  logic [KW-1:0]    mul_a;
  logic [MulBW-1:0] mul_b;
  logic [ProdW-1:0] mul_prod;
  logic             sqrt_start, sqrt_done;
  logic [RootW-1:0] root;
  logic             div_start, div_done;
  logic [DwellW-1:0] quo;

  assign cnt_inc   = done_cnt_q + 1'b1;
  assign rem       = total_q - done_cnt_q;
  assign half      = {done_cnt_q, 1'b0} < {1'b0, total_q};
  assign accel     = (p1_q < v2_q) && half;
  assign cruise    = (v2_q < mul_prod[SqW-1:0]) || half;
  assign rad_b     = (15'(n_q) << 6) + (15'(n_q) << 5) + (15'(n_q) << 2) + 15'd10;
  assign cruise_sp = (SpW'(v_q) << 3) + (SpW'(v_q) << 1);

  always_comb begin
    mul_a = k_q;
    mul_b = '0;
    unique case (state_q)
      ST_SQ:   begin
        mul_a = KW'(v_q);
        mul_b = v_q;
      end
      ST_P1:   mul_b = MulBW'(done_cnt_q);
      ST_P2:   mul_b = MulBW'(rem);
      ST_RAD:  mul_b = MulBW'(rad_b);
      default: mul_b = '0;
    endcase
  end

  assign mul_start  = go_q && ((state_q == ST_SQ) || (state_q == ST_P1) ||
                               (state_q == ST_P2) || (state_q == ST_RAD));
  assign sqrt_start = go_q && (state_q == ST_ROOT);
  assign div_start  = go_q && (state_q == ST_DIV);

  stp_mul #(
    .OpAW (KW),
    .OpBW (MulBW)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  stp_isqrt #(
    .XW (RadW)
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .x_i     (mul_prod[RadW-1:0]),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  stp_div #(
    .NW (DwellW),
    .DW (SpW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (DwellNum),
    .den_i   (sp_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // ---- control ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      go_q        <= 1'b0;
      v_q         <= VMin;
      k_q         <= 31'd200;
      pos_q       <= PosMax;
      total_q     <= '0;
      done_cnt_q  <= '0;
      moving_q    <= 1'b0;
      dir_neg_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      go_q <= 1'b0;
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_acc) begin
        unique case (cfg_reg_e'(cfg_i.index))
          REG_MAX_SPEED: v_q <= v_w;
          REG_ACCEL:     k_q <= (KW'(a_w) << 7) + (KW'(a_w) << 6) + (KW'(a_w) << 3);
          default:       v_q <= v_q;
        endcase
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (!in_i.req_type) begin
              dir_neg_q  <= diff[DegW];
              total_q    <= mag[StepW-1:0];
              done_cnt_q <= '0;
              moving_q   <= mag != '0;
            end else if (!moving_q) begin
              state_q <= ST_OUT;
            end else begin
              done_cnt_q <= cnt_inc;
              pos_q      <= dir_neg_q ? pos_q - 8'sd1 : pos_q + 8'sd1;
              if (cnt_inc == total_q) begin
                moving_q <= 1'b0;
              end
              state_q <= ST_SQ;
              go_q    <= 1'b1;
            end
          end
        end
        ST_SQ: begin
          if (mul_done) begin
            state_q <= ST_P1;
            go_q    <= 1'b1;
          end
        end
        ST_P1: begin
          if (mul_done) begin
            state_q <= ST_P2;
            go_q    <= 1'b1;
          end
        end
        ST_P2: begin
          if (mul_done) begin
            state_q <= (accel || !cruise) ? ST_RAD : ST_DIV;
            go_q    <= 1'b1;
          end
        end
        ST_RAD: begin
          if (mul_done) begin
            state_q <= ST_ROOT;
            go_q    <= 1'b1;
          end
        end
        ST_ROOT: begin
          if (sqrt_done) begin
            state_q <= ST_DIV;
            go_q    <= 1'b1;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // ---- datapath ----
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_IDLE) && in_acc && in_i.req_type) begin
      res_idle_q <= !moving_q;
      res_last_q <= moving_q && (cnt_inc == total_q);
      dwell_q    <= '0;
    end
    if ((state_q == ST_SQ) && mul_done) begin
      v2_q <= mul_prod[SqW-1:0];
    end
    if ((state_q == ST_P1) && mul_done) begin
      p1_q <= mul_prod[SqW-1:0];
    end
    if ((state_q == ST_P2) && mul_done) begin
      n_q  <= accel ? done_cnt_q : rem;
      sp_q <= cruise_sp;
    end
    if ((state_q == ST_ROOT) && sqrt_done) begin
      sp_q <= (root == '0) ? SpW'(1) : SpW'(root);
    end
    if ((state_q == ST_DIV) && div_done) begin
      dwell_q <= quo;
    end
    if ((state_q == ST_OUT) && out_free) begin
      out_pos_q   <= pos_q;
      out_pulse_q <= pulse_for(DegW'(pos_q) + DegW'(PosMax));
      out_dwell_q <= dwell_q;
      out_last_q  <= res_last_q;
      out_idle_q  <= res_idle_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.position_deg = out_pos_q;
  assign out_o.pulse_us     = out_pulse_q;
  assign out_o.dwell_us     = out_dwell_q;
  assign out_o.last_step    = out_last_q;
  assign out_o.idle         = out_idle_q;

  // ---- assertions ----
  `STP_ASSERT_IMPLIES(a_cnt_bound, clk_i, rst_ni, moving_q, done_cnt_q < total_q, "step count ran past move length")
  `STP_ASSERT_IMPLIES(a_pos_range, clk_i, rst_ni, 1'b1, (pos_q <= PosMax) && (pos_q >= PosMin), "position out of range")
  `STP_ASSERT_NEXT(a_step_busy, clk_i, rst_ni, in_acc && in_i.req_type && moving_q, (state_q == ST_SQ) && go_q, "step transfer did not launch sequencer")
  `STP_ASSERT_IMPLIES(a_last_not_idle, clk_i, rst_ni, out_valid_q && out_last_q, !out_idle_q, "idle result flagged as last step")

endmodule

`default_nettype wire
